FILE: src/hdlc_dfr_pkg.sv
package hdlc_dfr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;
   localparam int CRC_W  = 16;

   localparam logic [BYTE_W-1:0] FLAG_BOUNDARY = 8'h7E;
   localparam logic [BYTE_W-1:0] FLAG_ESCAPE   = 8'h7D;
   localparam logic [BYTE_W-1:0] ESCAPE_XOR    = 8'h20;
   localparam logic [CRC_W-1:0]  CRC_START     = 16'hFFFF;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic rd_first;
      logic rd_next;
      logic load_out;
      logic drop_out;
   } dfr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_flag;
      logic frame_good;
      logic out_last;
   } dfr_sts_type;

   // reflected crc-16-ccitt, one byte
   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] d;
      logic [CRC_W-1:0]  r;
      d = data ^ crc[7:0];
      d = d ^ {d[3:0], 4'b0000};
      r = {d, crc[15:8]};
      r = r ^ {12'h000, d[7:4]};
      r = r ^ {5'b00000, d, 3'b000};
      return r;
   endfunction

endpackage

FILE: src/hdlc_dfr_req_if.sv
interface hdlc_dfr_req_if;
   logic                              valid;
   logic                              ready;
   logic [hdlc_dfr_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/hdlc_dfr_rsp_if.sv
interface hdlc_dfr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hdlc_dfr_pkg::BYTE_W-1:0]   payload_byte;
   logic [hdlc_dfr_pkg::LEN_W-1:0]    payload_length;
   logic                              last_byte;

   modport source (output valid, output payload_byte, output payload_length,
                   output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input payload_length,
                   input last_byte, output ready);
endinterface

FILE: src/hdlc_crc16_deframer.sv
// a data or escape byte is taken while idle, one beat per cycle when no readout runs
// a boundary byte of a good frame starts the payload readout from the frame ram:
// each byte goes into the ram read register, then the output register, held there
// through any rsp stall; req ready stays low until the last payload beat is taken
// reset: synchronous, active high; clears fill count, escape mark, crc to all ones
// the frame ram itself is not cleared
module hdlc_crc16_deframer #(
   parameter int FRAME_CAPACITY = 64
) (
   input logic             clock,
   input logic             reset,
   hdlc_dfr_req_if.sink    req_ch,
   hdlc_dfr_rsp_if.source  rsp_ch
);

   hdlc_dfr_pkg::dfr_cmd_type cmd;
   hdlc_dfr_pkg::dfr_sts_type sts;

   hdlc_dfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hdlc_dfr_dp #(
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .rx_byte        (req_ch.rx_byte),
      .rsp_valid      (rsp_ch.valid),
      .payload_byte   (rsp_ch.payload_byte),
      .payload_length (rsp_ch.payload_length),
      .last_byte      (rsp_ch.last_byte)
   );

endmodule

FILE: src/hdlc_dfr_ram.sv
module hdlc_dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/hdlc_dfr_ctrl.sv
module hdlc_dfr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   input  hdlc_dfr_pkg::dfr_sts_type   sts,
   output hdlc_dfr_pkg::dfr_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEND
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_byte = req_valid;
            if (req_valid && sts.is_flag && sts.frame_good) begin
               cmd.rd_first = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // read data is out of the ram now
            cmd.load_out = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               cmd.drop_out = 1'b1;
               if (sts.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/hdlc_dfr_dp.sv
module hdlc_dfr_dp #(
   parameter int FRAME_CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hdlc_dfr_pkg::dfr_cmd_type         cmd,
   output hdlc_dfr_pkg::dfr_sts_type         sts,
   input  logic [hdlc_dfr_pkg::BYTE_W-1:0]   rx_byte,
   output logic                              rsp_valid,
   output logic [hdlc_dfr_pkg::BYTE_W-1:0]   payload_byte,
   output logic [hdlc_dfr_pkg::LEN_W-1:0]    payload_length,
   output logic                              last_byte
);

   localparam int AddrW = $clog2(FRAME_CAPACITY);
   localparam int CntW  = AddrW + 1;
   localparam int ByteW = hdlc_dfr_pkg::BYTE_W;
   localparam int CrcW  = hdlc_dfr_pkg::CRC_W;
   localparam int LenW  = hdlc_dfr_pkg::LEN_W;
   localparam logic [CntW-1:0] Capacity = CntW'(FRAME_CAPACITY);
   localparam logic [CntW-1:0] CrcBytes = CntW'(2);

   logic [CntW-1:0]  fill_ff, fill_in;
   logic [CrcW-1:0]  crc_ff, crc_in;
   logic             esc_ff, esc_in;
   logic [ByteW-1:0] hist0_ff, hist0_in;
   logic [ByteW-1:0] hist1_ff, hist1_in;
   logic [CntW-1:0]  len_ff, len_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic             out_valid_ff, out_valid_in;
   logic [ByteW-1:0] out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   logic             is_flag;
   logic             is_esc;
   logic [ByteW-1:0] data_byte;
   logic             wr_en;
   logic             rd_en;
   logic [AddrW-1:0] rd_addr;
   logic [ByteW-1:0] rd_data;

   assign is_flag   = (rx_byte == hdlc_dfr_pkg::FLAG_BOUNDARY);
   assign is_esc    = (rx_byte == hdlc_dfr_pkg::FLAG_ESCAPE);
   assign data_byte = esc_ff ? (rx_byte ^ hdlc_dfr_pkg::ESCAPE_XOR) : rx_byte;
   assign wr_en     = cmd.take_byte && !is_flag && !is_esc && (fill_ff < Capacity);

   assign sts.is_flag    = is_flag;
   // the two newest stored bytes carry the received crc, low byte first
   assign sts.frame_good = (fill_ff > CrcBytes) && ({hist0_ff, hist1_ff} == crc_ff);
   assign sts.out_last   = out_last_ff;

   assign rd_en   = cmd.rd_first || cmd.rd_next;
   assign rd_addr = cmd.rd_first ? '0 : rd_ptr_ff + AddrW'(1);

   always_comb begin
      fill_in      = fill_ff;
      crc_in       = crc_ff;
      esc_in       = esc_ff;
      hist0_in     = hist0_ff;
      hist1_in     = hist1_ff;
      len_in       = len_ff;
      rd_ptr_in    = rd_ptr_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (cmd.take_byte) begin
         if (is_flag) begin
            len_in  = fill_ff - CrcBytes;
            fill_in = '0;
            crc_in  = hdlc_dfr_pkg::CRC_START;
         end else if (is_esc) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            if (fill_ff < Capacity) begin
               fill_in  = fill_ff + CntW'(1);
               hist0_in = data_byte;
               hist1_in = hist0_ff;
               // crc trails the newest byte by two
               if (fill_ff >= CrcBytes) begin
                  crc_in = hdlc_dfr_pkg::crc_step(crc_ff, hist1_ff);
               end
            end
         end
      end

      if (rd_en) begin
         rd_ptr_in = rd_addr;
      end

      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data;
         out_last_in  = ({1'b0, rd_ptr_ff} == (len_ff - CntW'(1)));
      end else if (cmd.drop_out) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         crc_ff       <= hdlc_dfr_pkg::CRC_START;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         crc_ff       <= crc_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      hist0_ff    <= hist0_in;
      hist1_ff    <= hist1_in;
      len_ff      <= len_in;
      rd_ptr_ff   <= rd_ptr_in;
      out_byte_ff <= out_byte_in;
   end

   hdlc_dfr_ram #(
      .WIDTH (ByteW),
      .DEPTH (FRAME_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AddrW-1:0]),
      .wr_data (data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid      = out_valid_ff;
   assign payload_byte   = out_byte_ff;
   assign payload_length = LenW'(len_ff);
   assign last_byte      = out_last_ff;

endmodule

FILE: test/hdlc_crc16_deframer_tb.sv
module hdlc_crc16_deframer_tb;

   localparam int CAP          = 64;
   localparam int MAX_PAYLOAD  = CAP - 2;
   localparam int RANDOM_ITEMS = 450;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam logic [hdlc_dfr_pkg::CRC_W-1:0] FCS_POLY = 16'h8408;

   typedef enum logic {ROW_SILENT, ROW_PREDICTED} row_kind_type;
   typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_COMB} ready_mode_type;

   typedef logic [hdlc_dfr_pkg::BYTE_W-1:0] byte_type;
   typedef logic [hdlc_dfr_pkg::CRC_W-1:0]  fcs_type;

   typedef struct {
      byte_type     rx_byte;
      row_kind_type kind;
   } line_row_type;

   typedef struct {
      byte_type                         data;
      logic [hdlc_dfr_pkg::LEN_W-1:0]   len;
      logic                             last;
   } payload_beat_type;

   typedef byte_type byte_q_type[$];

   logic clock = 1'b0;
   logic reset;

   hdlc_dfr_req_if req_bus ();
   hdlc_dfr_rsp_if rsp_bus ();

   hdlc_crc16_deframer #(
      .FRAME_CAPACITY(CAP)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_row_type     line_bytes[$];
   payload_beat_type pending_payload[$];
   row_kind_type     cur_kind = ROW_SILENT;
   int               sent_cnt = 0;
   int               fail_cnt = 0;
   int               long_hold_at = 32'h7FFF_FFFF;
   int               pause_at = 32'h7FFF_FFFF;

   // deframer state as the block should hold it
   byte_type frame_mem [CAP];
   int       fill_cnt = 0;
   fcs_type  fcs_acc = hdlc_dfr_pkg::CRC_START;
   bit       esc_armed = 1'b0;

   function automatic fcs_type fcs16_update(input fcs_type c, input byte_type b);
      fcs_type r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ FCS_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic void deframe_byte(input byte_type b, input bit keep);
      byte_type         d;
      fcs_type          rx_fcs;
      payload_beat_type pb;
      int               n;
      if (b == hdlc_dfr_pkg::FLAG_BOUNDARY) begin
         if (fill_cnt > 2) begin
            rx_fcs = {frame_mem[fill_cnt-1], frame_mem[fill_cnt-2]};
            if (rx_fcs == fcs_acc && keep) begin
               n = fill_cnt - 2;
               for (int k = 0; k < n; k++) begin
                  pb.data = frame_mem[k];
                  pb.len  = n[hdlc_dfr_pkg::LEN_W-1:0];
                  pb.last = (k == n - 1);
                  pending_payload.insert(pending_payload.size(), pb);
               end
            end
         end
         fill_cnt = 0;
         fcs_acc  = hdlc_dfr_pkg::CRC_START;
      end else if (b == hdlc_dfr_pkg::FLAG_ESCAPE) begin
         esc_armed = 1'b1;
      end else begin
         d = b;
         if (esc_armed) begin
            d = d ^ hdlc_dfr_pkg::ESCAPE_XOR;
            esc_armed = 1'b0;
         end
         // bytes past capacity are dropped, the escape is still used up
         if (fill_cnt < CAP) begin
            frame_mem[fill_cnt] = d;
            fill_cnt++;
            if (fill_cnt > 2) fcs_acc = fcs16_update(fcs_acc, frame_mem[fill_cnt-3]);
         end
      end
   endfunction

   function automatic void add_row(input byte_type b, input row_kind_type kind);
      line_row_type row;
      row.rx_byte = b;
      row.kind    = kind;
      line_bytes.insert(line_bytes.size(), row);
   endfunction

   // payload plus fcs, low byte first, byte-stuffed
   function automatic void add_body(input byte_q_type pl, input bit bad_fcs, input bit lead_esc,
                                    input bit dup_esc, input row_kind_type kind);
      fcs_type    fcs;
      byte_type   b;
      byte_type   lx;
      byte_q_type fr;
      fcs = hdlc_dfr_pkg::CRC_START;
      foreach (pl[i]) fcs = fcs16_update(fcs, pl[i]);
      if (bad_fcs) fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
      fr = pl;
      fr.insert(fr.size(), fcs[7:0]);
      fr.insert(fr.size(), fcs[15:8]);
      foreach (fr[i]) begin
         b  = fr[i];
         lx = b ^ hdlc_dfr_pkg::ESCAPE_XOR;
         // an escape is already armed: send the first byte pre-flipped
         if (i == 0 && lead_esc && lx != hdlc_dfr_pkg::FLAG_BOUNDARY &&
             lx != hdlc_dfr_pkg::FLAG_ESCAPE) begin
            add_row(lx, kind);
         end else if (b == hdlc_dfr_pkg::FLAG_BOUNDARY || b == hdlc_dfr_pkg::FLAG_ESCAPE) begin
            add_row(hdlc_dfr_pkg::FLAG_ESCAPE, kind);
            if (dup_esc) add_row(hdlc_dfr_pkg::FLAG_ESCAPE, kind);
            add_row(lx, kind);
         end else begin
            add_row(b, kind);
         end
      end
   endfunction

   function automatic byte_q_type rand_payload(input int n);
      byte_q_type q;
      byte_type   t;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0)
            t = $urandom_range(0, 1) ? hdlc_dfr_pkg::FLAG_BOUNDARY : hdlc_dfr_pkg::FLAG_ESCAPE;
         else
            t = byte_type'($urandom_range(0, 255));
         q.insert(q.size(), t);
      end
      return q;
   endfunction

   function automatic byte_type rand_plain(input bit allow_esc);
      byte_type t;
      do begin
         t = byte_type'($urandom_range(0, 255));
      end while (t == hdlc_dfr_pkg::FLAG_BOUNDARY ||
                 (!allow_esc && t == hdlc_dfr_pkg::FLAG_ESCAPE));
      return t;
   endfunction

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 8);
      else if (r < 95) return $urandom_range(9, 30);
      return $urandom_range(31, MAX_PAYLOAD);
   endfunction

   always @(posedge clock) begin
      payload_beat_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_payload.size() == 0) begin
               $error("payload_byte expected none actual %02h", rsp_bus.payload_byte);
               fail_cnt++;
            end else begin
               want = pending_payload.pop_front();
               if (rsp_bus.payload_byte !== want.data) begin
                  $error("payload_byte expected %02h actual %02h", want.data,
                         rsp_bus.payload_byte);
                  fail_cnt++;
               end
               if (rsp_bus.payload_length !== want.len) begin
                  $error("payload_length expected %0d actual %0d", want.len,
                         rsp_bus.payload_length);
                  fail_cnt++;
               end
               if (rsp_bus.last_byte !== want.last) begin
                  $error("last_byte expected %0b actual %0b", want.last, rsp_bus.last_byte);
                  fail_cnt++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            deframe_byte(req_bus.rx_byte, cur_kind == ROW_PREDICTED);
      end
   end

   // result side stalls
   initial begin
      int             hold_left;
      int             mode_left;
      int             stall_tick;
      bit             held;
      ready_mode_type mode;
      hold_left  = 0;
      mode_left  = 0;
      stall_tick = 0;
      held       = 1'b0;
      mode       = RDY_ALWAYS;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         stall_tick++;
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 80);
         end
         mode_left--;
         // one long hold-off while a readout is under way
         if (!held && sent_cnt > long_hold_at && rsp_bus.valid === 1'b1) begin
            hold_left = LONG_HOLD;
            held      = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RDY_ALWAYS: rsp_bus.ready <= 1'b1;
               RDY_HALF:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RDY_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:    rsp_bus.ready <= stall_tick[2];
            endcase
         end
      end
   end

   initial begin
      int      cycle_cnt;
      for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      byte_q_type pl;
      int         r;
      int         n;
      int         gap;
      int         burst_left;
      int         directed_n;

      reset <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;

      // directed rows: short frames and a bad fcs must stay silent
      add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_SILENT);
      add_row(8'h00, ROW_SILENT);
      add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_SILENT);
      add_row(8'hFF, ROW_SILENT);
      add_row(8'h01, ROW_SILENT);
      add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_SILENT);
      pl = '{8'h55};
      add_body(pl, 1'b1, 1'b0, 1'b0, ROW_SILENT);
      // escape left armed across the boundary
      add_row(hdlc_dfr_pkg::FLAG_ESCAPE, ROW_SILENT);
      add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_SILENT);
      // three stored bytes, first one unescaped by the armed escape
      pl = '{hdlc_dfr_pkg::FLAG_BOUNDARY};
      add_body(pl, 1'b0, 1'b1, 1'b0, ROW_PREDICTED);
      add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
      // byte extremes with a repeated escape
      pl = '{8'h00, 8'hFF, hdlc_dfr_pkg::FLAG_ESCAPE};
      add_body(pl, 1'b0, 1'b0, 1'b1, ROW_PREDICTED);
      add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);

      directed_n   = line_bytes.size();
      long_hold_at = directed_n + 30;
      pause_at     = directed_n + 220;

      for (int s = 0; line_bytes.size() < directed_n + RANDOM_ITEMS; s++) begin
         // start with a store overflow, then the longest payload
         r = (s == 0) ? 65 : (s == 1) ? 0 : $urandom_range(0, 99);
         n = (s == 1) ? MAX_PAYLOAD : pick_len();
         if (r < 55) begin
            pl = rand_payload(n);
            add_body(pl, 1'b0, 1'b0, $urandom_range(0, 7) == 0, ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
         end else if (r < 65) begin
            pl = rand_payload(n);
            add_body(pl, 1'b1, 1'b0, 1'b0, ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
         end else if (r < 72) begin
            pl = rand_payload(MAX_PAYLOAD);
            add_body(pl, $urandom_range(0, 3) == 0, 1'b0, 1'b0, ROW_PREDICTED);
            repeat ($urandom_range(1, 8)) add_row(rand_plain(1'b1), ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
         end else if (r < 80) begin
            repeat ($urandom_range(0, 2)) add_row(rand_plain(1'b0), ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
         end else if (r < 88) begin
            repeat ($urandom_range(1, 6))
               add_row(byte_type'($urandom_range(0, 255)), ROW_PREDICTED);
         end else if (r < 94) begin
            pl = rand_payload(n);
            add_body(pl, 1'b0, 1'b0, 1'b0, ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_ESCAPE, ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
            pl = rand_payload(pick_len());
            add_body(pl, 1'b0, 1'b1, 1'b0, ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
         end else begin
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
            add_row(hdlc_dfr_pkg::FLAG_BOUNDARY, ROW_PREDICTED);
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      burst_left = $urandom_range(1, 24);
      while (sent_cnt < line_bytes.size()) begin
         // let the block drain completely once
         if (sent_cnt == pause_at) begin
            while (pending_payload.size() != 0) begin
               req_bus.valid <= 1'b0;
               @(negedge clock);
            end
         end
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
               req_bus.valid <= 1'b0;
               @(negedge clock);
            end
         end
         cur_kind = line_bytes[sent_cnt].kind;
         req_bus.valid   <= 1'b1;
         req_bus.rx_byte <= line_bytes[sent_cnt].rx_byte;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         sent_cnt++;
         burst_left--;
         @(negedge clock);
      end
      req_bus.valid <= 1'b0;

      while (pending_payload.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
